>>> src/dns_answer_record_parser_defines.svh
// assertion macros for the dns answer record parser
`ifndef DNS_ANSWER_RECORD_PARSER_DEFINES_SVH
`define DNS_ANSWER_RECORD_PARSER_DEFINES_SVH

// same-cycle implication, checked at every clock edge out of reset
`define DNSARP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dns answer record parser: same-cycle check failed");

// next-cycle implication, checked at every clock edge out of reset
`define DNSARP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dns answer record parser: next-cycle check failed");

`endif

>>> src/dnsarp_pkg.sv
`timescale 1ns / 1ps

package dnsarp_pkg;

    // fixed message layout
    localparam int HEADER_BYTES  = 12;
    localparam int ANCOUNT_HI    = 6;
    localparam int ANCOUNT_LO    = 7;
    localparam int QTAIL_BYTES   = 4;
    localparam int PTR_BYTES     = 2;
    localparam int TYPE_BYTES    = 2;
    localparam int CLASS_BYTES   = 2;
    localparam int TTL_BYTES     = 4;
    localparam int RDLEN_BYTES   = 2;
    localparam int ADDR_BYTES    = 4;

    // result kinds
    typedef enum logic [1:0] {
        KIND_RECORD    = 2'd0,
        KIND_COMPLETE  = 2'd1,
        KIND_SHORT     = 2'd2,
        KIND_TRUNCATED = 2'd3
    } kind_t;

    // parser phases
    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_QNAME  = 4'd1,
        PH_QTAIL  = 4'd2,
        PH_NAME   = 4'd3,
        PH_TYPE   = 4'd4,
        PH_CLASS  = 4'd5,
        PH_TTL    = 4'd6,
        PH_RDLEN  = 4'd7,
        PH_RDATA  = 4'd8,
        PH_DONE   = 4'd9
    } phase_t;

    // one result item
    typedef struct packed {
        kind_t       kind;
        logic [31:0] ttl;
        logic [31:0] address;
        logic        length_ok;
        logic [15:0] record_count;
        logic        is_last;
    } result_t;

endpackage

>>> src/dns_answer_record_parser.sv
`timescale 1ns / 1ps
// output: results of a byte are written to the result queue and wait there behind older results
// throughput: one byte per cycle while each byte gives at most one result and
//   the output is drained; a byte that gives a record and a summary pushes two
//   results, absorbed by a four-entry result queue
// reset: rst_n clears the parser state, the queue and wanted_type (to 1)
`include "dns_answer_record_parser_defines.svh"

module dns_answer_record_parser #(
    parameter int MAX_MESSAGE_BYTES = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_write_en,
    input  logic [15:0]          cfg_write_data,
    // byte input
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    // result output
    output logic                 out_valid,
    input  logic                 out_ready,
    output dnsarp_pkg::kind_t    kind,
    output logic [31:0]          ttl,
    output logic [31:0]          address,
    output logic                 length_ok,
    output logic [15:0]          record_count,
    output logic                 is_last
);

    import dnsarp_pkg::*;

    localparam int MB_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam logic [MB_W-1:0] MB_LIMIT   = MB_W'(MAX_MESSAGE_BYTES);
    localparam logic [MB_W-1:0] MB_AN_HI   = MB_W'(ANCOUNT_HI);
    localparam logic [MB_W-1:0] MB_AN_LO   = MB_W'(ANCOUNT_LO);
    localparam logic [MB_W-1:0] MB_HDR_END = MB_W'(HEADER_BYTES - 1);
    localparam logic [MB_W-1:0] MB_HDR     = MB_W'(HEADER_BYTES);

    localparam int Q_DEPTH = 4;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    // configuration register
    logic [15:0] wanted_type_reg;

    // parser state
    phase_t          phase_reg, phase_next;
    logic [2:0]      bif_reg, bif_next;
    logic [15:0]     answers_reg, answers_next;
    logic [15:0]     rtype_reg, rtype_next;
    logic [31:0]     ttl_reg, ttl_next;
    logic [15:0]     dleft_reg, dleft_next;
    logic [31:0]     addr_reg, addr_next;
    logic [15:0]     matches_reg, matches_next;
    logic [MB_W-1:0] mbytes_reg, mbytes_next;
    logic            len4_reg, len4_next;

    // result queue
    result_t         q_reg [Q_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0] count_reg;

    logic            in_xfer, out_xfer;
    logic [1:0]      n_push;
    result_t         res0, res1;

    assign in_ready = (count_reg <= QC_W'(Q_DEPTH - 2));
    assign in_xfer  = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign out_xfer  = out_valid && out_ready;

    // wanted type register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_type_reg <= 16'd1;
        end
        else if (cfg_write_en)
        begin
            wanted_type_reg <= cfg_write_data;
        end
    end

    // next parser state and results of one byte
    always_comb
    begin
        logic [2:0]  bif_inc;
        logic [15:0] dl_new;
        logic [15:0] ans_dec;
        logic        finish;
        logic        rec_ready;
        kind_t       sum_kind;

        phase_next   = phase_reg;
        bif_next     = bif_reg;
        answers_next = answers_reg;
        rtype_next   = rtype_reg;
        ttl_next     = ttl_reg;
        dleft_next   = dleft_reg;
        addr_next    = addr_reg;
        matches_next = matches_reg;
        mbytes_next  = mbytes_reg;
        len4_next    = len4_reg;

        bif_inc   = bif_reg + 3'd1;
        dl_new    = {dleft_reg[7:0], data_byte};
        ans_dec   = answers_reg - 16'd1;
        finish    = 1'b0;
        rec_ready = 1'b0;
        sum_kind  = KIND_TRUNCATED;
        n_push    = 2'd0;
        res0      = '0;
        res1      = '0;

        if (in_xfer)
        begin
            // walk the message layout, ignoring bytes past the size limit
            if (mbytes_reg < MB_LIMIT)
            begin
                mbytes_next = mbytes_reg + MB_W'(1);
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (mbytes_reg == MB_AN_HI)
                            answers_next = {data_byte, 8'd0};
                        if (mbytes_reg == MB_AN_LO)
                            answers_next = answers_reg | {8'd0, data_byte};
                        if (mbytes_reg == MB_HDR_END)
                            phase_next = PH_QNAME;
                    end
                    PH_QNAME:
                    begin
                        if (data_byte == 8'd0)
                        begin
                            phase_next = PH_QTAIL;
                            bif_next   = 3'd0;
                        end
                    end
                    PH_QTAIL:
                    begin
                        if (bif_inc == 3'(QTAIL_BYTES))
                        begin
                            bif_next   = 3'd0;
                            phase_next = (answers_reg == 16'd0) ? PH_DONE : PH_NAME;
                        end
                        else
                            bif_next = bif_inc;
                    end
                    PH_NAME:
                    begin
                        if (bif_inc == 3'(PTR_BYTES))
                        begin
                            phase_next = PH_TYPE;
                            bif_next   = 3'd0;
                            rtype_next = 16'd0;
                        end
                        else
                            bif_next = bif_inc;
                    end
                    PH_TYPE:
                    begin
                        rtype_next = {rtype_reg[7:0], data_byte};
                        if (bif_inc == 3'(TYPE_BYTES))
                        begin
                            phase_next = PH_CLASS;
                            bif_next   = 3'd0;
                        end
                        else
                            bif_next = bif_inc;
                    end
                    PH_CLASS:
                    begin
                        if (bif_inc == 3'(CLASS_BYTES))
                        begin
                            phase_next = PH_TTL;
                            bif_next   = 3'd0;
                            ttl_next   = 32'd0;
                        end
                        else
                            bif_next = bif_inc;
                    end
                    PH_TTL:
                    begin
                        ttl_next = {ttl_reg[23:0], data_byte};
                        if (bif_inc == 3'(TTL_BYTES))
                        begin
                            phase_next = PH_RDLEN;
                            bif_next   = 3'd0;
                            dleft_next = 16'd0;
                        end
                        else
                            bif_next = bif_inc;
                    end
                    PH_RDLEN:
                    begin
                        dleft_next = dl_new;
                        if (bif_inc == 3'(RDLEN_BYTES))
                        begin
                            len4_next = (dl_new == 16'(ADDR_BYTES));
                            addr_next = 32'd0;
                            bif_next  = 3'd0;
                            if (dl_new == 16'd0)
                                finish = 1'b1;
                            else
                                phase_next = PH_RDATA;
                        end
                        else
                            bif_next = bif_inc;
                    end
                    PH_RDATA:
                    begin
                        if (bif_reg < 3'(ADDR_BYTES))
                        begin
                            addr_next = {addr_reg[23:0], data_byte};
                            bif_next  = bif_inc;
                        end
                        dleft_next = dleft_reg - 16'd1;
                        if (dleft_reg == 16'd1)
                            finish = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase

                // end of one answer record
                if (finish)
                begin
                    if (rtype_reg == wanted_type_reg)
                    begin
                        matches_next = matches_reg + 16'd1;
                        rec_ready    = 1'b1;
                    end
                    answers_next = ans_dec;
                    bif_next     = 3'd0;
                    phase_next   = (ans_dec == 16'd0) ? PH_DONE : PH_NAME;
                end
            end

            // record result
            if (rec_ready)
            begin
                res0.kind         = KIND_RECORD;
                res0.ttl          = ttl_next;
                res0.address      = addr_next;
                res0.length_ok    = len4_next;
                res0.record_count = matches_next;
                res0.is_last      = !last_byte;
            end

            // message summary, then back to a fresh message
            if (last_byte)
            begin
                priority if (mbytes_next < MB_HDR)
                    sum_kind = KIND_SHORT;
                else if (phase_next == PH_DONE)
                    sum_kind = KIND_COMPLETE;
                else
                    sum_kind = KIND_TRUNCATED;

                res1.kind         = sum_kind;
                res1.ttl          = 32'd0;
                res1.address      = 32'd0;
                res1.length_ok    = 1'b0;
                res1.record_count = matches_next;
                res1.is_last      = 1'b1;
                if (!rec_ready)
                    res0 = res1;

                phase_next   = PH_HEADER;
                bif_next     = 3'd0;
                answers_next = 16'd0;
                rtype_next   = 16'd0;
                ttl_next     = 32'd0;
                dleft_next   = 16'd0;
                addr_next    = 32'd0;
                matches_next = 16'd0;
                mbytes_next  = '0;
                len4_next    = 1'b0;
            end

            n_push = 2'(rec_ready) + 2'(last_byte);
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            bif_reg     <= 3'd0;
            answers_reg <= 16'd0;
            rtype_reg   <= 16'd0;
            ttl_reg     <= 32'd0;
            dleft_reg   <= 16'd0;
            addr_reg    <= 32'd0;
            matches_reg <= 16'd0;
            mbytes_reg  <= '0;
            len4_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            bif_reg     <= bif_next;
            answers_reg <= answers_next;
            rtype_reg   <= rtype_next;
            ttl_reg     <= ttl_next;
            dleft_reg   <= dleft_next;
            addr_reg    <= addr_next;
            matches_reg <= matches_next;
            mbytes_reg  <= mbytes_next;
            len4_reg    <= len4_next;
        end
    end

    // result queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QP_W'(n_push);
            if (out_xfer)
                rd_ptr_reg <= rd_ptr_reg + QP_W'(1);
            count_reg <= count_reg + QC_W'(n_push) - QC_W'(out_xfer);
        end
    end

    // result queue payload
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            q_reg[wr_ptr_reg] <= res0;
        if (n_push == 2'd2)
            q_reg[wr_ptr_reg + QP_W'(1)] <= res1;
    end

    // head of queue drives the output
    assign kind         = q_reg[rd_ptr_reg].kind;
    assign ttl          = q_reg[rd_ptr_reg].ttl;
    assign address      = q_reg[rd_ptr_reg].address;
    assign length_ok    = q_reg[rd_ptr_reg].length_ok;
    assign record_count = q_reg[rd_ptr_reg].record_count;
    assign is_last      = q_reg[rd_ptr_reg].is_last;

    // checks
    `DNSARP_ASSERT_NEXT(a_last_clears, in_xfer && last_byte, phase_reg == PH_HEADER && mbytes_reg == '0 && matches_reg == 16'd0)
    `DNSARP_ASSERT_NOW(a_summary_queued, out_valid && !is_last, count_reg >= QC_W'(2))
    `DNSARP_ASSERT_NEXT(a_done_holds, in_xfer && !last_byte && phase_reg == PH_DONE, phase_reg == PH_DONE)

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import dnsarp_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PARSE_LIMIT = 256;
    localparam int GAP_CAP     = 30;
    localparam int PRINT_CAP   = 40;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_write_en   = 1'b0;
    logic [15:0] cfg_write_data = 16'h0000;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte      = 8'h00;
    logic        last_byte      = 1'b0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    kind_t       kind;
    logic [31:0] ttl;
    logic [31:0] address;
    logic        length_ok;
    logic [15:0] record_count;
    logic        is_last;

    dns_answer_record_parser #(
        .MAX_MESSAGE_BYTES(PARSE_LIMIT)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .ttl            (ttl),
        .address        (address),
        .length_ok      (length_ok),
        .record_count   (record_count),
        .is_last        (is_last)
    );

    always #6 clk = ~clk;

    // run bookkeeping
    int cycle_count    = 0;
    int mismatch_count = 0;
    int bytes_sent     = 0;
    int messages_sent  = 0;
    int type_settings  = 0;
    int records_seen   = 0;
    int summaries_seen = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    // shadow parser state
    logic [15:0] want_type = 16'd1;
    phase_t      pr_phase;
    int          pr_field;
    logic [15:0] pr_answers;
    logic [15:0] pr_rtype;
    logic [31:0] pr_ttl;
    logic [15:0] pr_dleft;
    logic [31:0] pr_addr;
    logic [15:0] pr_matches;
    int          pr_bytes;
    logic        pr_len4;
    logic        pr_rec_due;

    result_t     results_due[$];
    logic [7:0]  msg_q[$];

    // queue helpers
    function automatic void add_byte(input logic [7:0] b);
        msg_q.insert(msg_q.size(), b);
    endfunction

    function automatic void queue_result(input result_t r);
        results_due.insert(results_due.size(), r);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d", kind));
            end
            else
            begin
                want = results_due.pop_front();
                if (kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, predicted %0d", kind, want.kind));
                if (ttl !== want.ttl)
                    report_mismatch($sformatf("ttl %0h, predicted %0h", ttl, want.ttl));
                if (address !== want.address)
                    report_mismatch($sformatf("address %0h, predicted %0h",
                                              address, want.address));
                if (length_ok !== want.length_ok)
                    report_mismatch($sformatf("length_ok %0b, predicted %0b",
                                              length_ok, want.length_ok));
                if (record_count !== want.record_count)
                    report_mismatch($sformatf("record_count %0d, predicted %0d",
                                              record_count, want.record_count));
                if (is_last !== want.is_last)
                    report_mismatch($sformatf("is_last %0b, predicted %0b",
                                              is_last, want.is_last));
                if (want.kind == KIND_RECORD)
                    records_seen++;
                else
                    summaries_seen++;
            end
        end
    end

    // shadow parser
    function automatic void clear_parse_state();
        pr_phase   = PH_HEADER;
        pr_field   = 0;
        pr_answers = '0;
        pr_rtype   = '0;
        pr_ttl     = '0;
        pr_dleft   = '0;
        pr_addr    = '0;
        pr_matches = '0;
        pr_bytes   = 0;
        pr_len4    = 1'b0;
        pr_rec_due = 1'b0;
    endfunction

    function automatic void to_next_answer();
        pr_field = 0;
        pr_phase = (pr_answers == 16'd0) ? PH_DONE : PH_NAME;
    endfunction

    function automatic void close_record();
        if (pr_rtype == want_type)
        begin
            pr_matches = pr_matches + 16'd1;
            pr_rec_due = 1'b1;
        end
        pr_answers = pr_answers - 16'd1;
        to_next_answer();
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic lst);
        result_t r;
        pr_rec_due = 1'b0;
        if (pr_bytes < PARSE_LIMIT)
        begin
            case (pr_phase)
                PH_HEADER:
                begin
                    if (pr_bytes == ANCOUNT_HI)
                        pr_answers = {b, 8'h00};
                    if (pr_bytes == ANCOUNT_LO)
                        pr_answers = pr_answers | {8'h00, b};
                    if (pr_bytes == HEADER_BYTES - 1)
                        pr_phase = PH_QNAME;
                end
                PH_QNAME:
                begin
                    if (b == 8'h00)
                    begin
                        pr_phase = PH_QTAIL;
                        pr_field = 0;
                    end
                end
                PH_QTAIL:
                begin
                    pr_field++;
                    if (pr_field == QTAIL_BYTES)
                        to_next_answer();
                end
                PH_NAME:
                begin
                    pr_field++;
                    if (pr_field == PTR_BYTES)
                    begin
                        pr_phase = PH_TYPE;
                        pr_field = 0;
                        pr_rtype = '0;
                    end
                end
                PH_TYPE:
                begin
                    pr_rtype = {pr_rtype[7:0], b};
                    pr_field++;
                    if (pr_field == TYPE_BYTES)
                    begin
                        pr_phase = PH_CLASS;
                        pr_field = 0;
                    end
                end
                PH_CLASS:
                begin
                    pr_field++;
                    if (pr_field == CLASS_BYTES)
                    begin
                        pr_phase = PH_TTL;
                        pr_field = 0;
                        pr_ttl   = '0;
                    end
                end
                PH_TTL:
                begin
                    pr_ttl = {pr_ttl[23:0], b};
                    pr_field++;
                    if (pr_field == TTL_BYTES)
                    begin
                        pr_phase = PH_RDLEN;
                        pr_field = 0;
                        pr_dleft = '0;
                    end
                end
                PH_RDLEN:
                begin
                    pr_dleft = {pr_dleft[7:0], b};
                    pr_field++;
                    if (pr_field == RDLEN_BYTES)
                    begin
                        pr_len4  = (pr_dleft == 16'd4);
                        pr_addr  = '0;
                        pr_field = 0;
                        if (pr_dleft == 16'd0)
                            close_record();
                        else
                            pr_phase = PH_RDATA;
                    end
                end
                PH_RDATA:
                begin
                    // only the first four data bytes form the address
                    if (pr_field < ADDR_BYTES)
                    begin
                        pr_addr = {pr_addr[23:0], b};
                        pr_field++;
                    end
                    pr_dleft = pr_dleft - 16'd1;
                    if (pr_dleft == 16'd0)
                        close_record();
                end
                default:
                begin
                end
            endcase
            pr_bytes++;
        end

        if (pr_rec_due)
        begin
            r.kind         = KIND_RECORD;
            r.ttl          = pr_ttl;
            r.address      = pr_addr;
            r.length_ok    = pr_len4;
            r.record_count = pr_matches;
            r.is_last      = !lst;
            queue_result(r);
        end

        // end-of-message summary
        if (lst)
        begin
            if (pr_bytes < HEADER_BYTES)
                r.kind = KIND_SHORT;
            else if (pr_phase == PH_DONE)
                r.kind = KIND_COMPLETE;
            else
                r.kind = KIND_TRUNCATED;
            r.ttl          = '0;
            r.address      = '0;
            r.length_ok    = 1'b0;
            r.record_count = pr_matches;
            r.is_last      = 1'b1;
            queue_result(r);
            clear_parse_state();
        end
    endfunction

    // one byte transfer, with a random gap before it
    task automatic send_byte(input logic [7:0] value, input logic final_mark);
        int gap;
        gap = 0;
        while (gap < GAP_CAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        last_byte <= final_mark;
        do
            @(posedge clk);
        while (!in_ready);
        parse_byte(value, final_mark);
        bytes_sent++;
    endtask

    // hold off until every predicted result has come, then let the pipe empty
    task automatic settle_parser();
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_wanted_type(input logic [15:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        want_type = value;
        type_settings++;
    endtask

    // message building
    function automatic void begin_message(input int answers);
        msg_q.delete();
        for (int i = 0; i < HEADER_BYTES; i++)
            add_byte(8'($urandom_range(255)));
        msg_q[ANCOUNT_HI] = answers[15:8];
        msg_q[ANCOUNT_LO] = answers[7:0];
    endfunction

    function automatic void add_question(input int name_len);
        for (int i = 0; i < name_len; i++)
            add_byte(8'($urandom_range(1, 255)));
        add_byte(8'h00);
        for (int i = 0; i < QTAIL_BYTES; i++)
            add_byte(8'($urandom_range(255)));
    endfunction

    function automatic void add_record(input logic [15:0] rtype, input logic [31:0] life,
                                       input int dlen);
        add_byte(8'($urandom_range(255)));
        add_byte(8'($urandom_range(255)));
        add_byte(rtype[15:8]);
        add_byte(rtype[7:0]);
        add_byte(8'($urandom_range(255)));
        add_byte(8'($urandom_range(255)));
        for (int i = 3; i >= 0; i--)
            add_byte(life[8*i +: 8]);
        add_byte(dlen[15:8]);
        add_byte(dlen[7:0]);
        for (int i = 0; i < dlen; i++)
            add_byte(8'($urandom_range(255)));
    endfunction

    function automatic void add_noise(input int count);
        for (int i = 0; i < count; i++)
            add_byte(8'($urandom_range(255)));
    endfunction

    // send the first keep bytes, or all of them, marking the final one
    task automatic send_message(input int keep);
        int n;
        n = (keep <= 0 || keep > msg_q.size()) ? msg_q.size() : keep;
        for (int i = 0; i < n; i++)
            send_byte(msg_q[i], i == n - 1);
        messages_sent++;
    endtask

    task automatic test_short_messages();
        begin_message(1);
        send_message(1);
        send_message(HEADER_BYTES - 1);
        // header only, so it stops in the question
        send_message(HEADER_BYTES);
        settle_parser();
    endtask

    task automatic test_basic_records();
        // no answers at all
        begin_message(0);
        add_question(7);
        send_message(0);
        // mixed records followed by trailing bytes
        begin_message(3);
        add_question(3);
        add_record(16'd1, 32'hFFFF_FFFF, 4);
        add_record(16'd28, 32'h0000_0000, 16);
        add_record(16'd1, 32'h0000_0000, 4);
        add_noise(5);
        send_message(0);
        // end mark on the final data byte gives a record and a summary together
        begin_message(1);
        add_question(0);
        add_record(16'd1, 32'h8000_0001, 4);
        send_message(0);
        settle_parser();
    endtask

    task automatic test_data_lengths();
        begin_message(7);
        add_question(2);
        add_record(16'd1, 32'h0000_0e10, 0);
        add_record(16'd1, 32'h0000_0001, 1);
        add_record(16'd1, 32'h7FFF_FFFF, 2);
        add_record(16'd1, 32'h1234_5678, 3);
        add_record(16'd1, 32'hDEAD_BEEF, 5);
        add_record(16'd1, 32'h0000_0100, 9);
        add_record(16'd1, 32'hFFFF_FFFE, 4);
        send_message(0);
        settle_parser();
    endtask

    task automatic test_cut_off();
        int full;
        // stops inside the second record
        begin_message(2);
        add_question(4);
        add_record(16'd1, 32'h0000_003c, 4);
        add_record(16'd1, 32'h0000_003c, 4);
        send_message(msg_q.size() - 3);
        // stops in the question tail
        begin_message(1);
        add_question(4);
        full = HEADER_BYTES + 4 + 1 + 2;
        send_message(full);
        // more answers claimed than present
        begin_message(4);
        add_question(1);
        add_record(16'd1, 32'h0000_0005, 4);
        send_message(0);
        settle_parser();
    endtask

    task automatic test_type_config();
        write_wanted_type(16'h0000);
        begin_message(3);
        add_question(2);
        add_record(16'h0000, 32'h0000_0011, 4);
        add_record(16'h0001, 32'h0000_0022, 4);
        add_record(16'h0000, 32'h0000_0033, 2);
        send_message(0);
        settle_parser();
        write_wanted_type(16'hFFFF);
        begin_message(2);
        add_question(2);
        add_record(16'hFFFF, 32'hFFFF_FFFF, 4);
        add_record(16'hFF00, 32'h0000_0044, 4);
        send_message(0);
        settle_parser();
        write_wanted_type(16'h0001);
    endtask

    task automatic test_oversize();
        // data runs past the size limit, end mark lies beyond it
        begin_message(1);
        add_question(3);
        add_record(16'd1, 32'h0000_0078, PARSE_LIMIT + 80);
        send_message(PARSE_LIMIT + 20);
        // parser must recover for the next message
        begin_message(1);
        add_question(3);
        add_record(16'd1, 32'h0000_0078, 4);
        send_message(0);
        settle_parser();
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int target);
        int          start;
        int          n_rec;
        int          claimed;
        int          keep;
        int          dlen;
        logic [15:0] rtype;
        logic [31:0] life;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            if ($urandom_range(99) < 8)
            begin
                // garbage message
                msg_q.delete();
                add_noise($urandom_range(1, 30));
                send_message(0);
            end
            else
            begin
                n_rec   = $urandom_range(0, 4);
                claimed = n_rec;
                if ($urandom_range(9) == 0)
                    claimed = n_rec + $urandom_range(1, 3);
                begin_message(claimed);
                add_question($urandom_range(0, 12));
                for (int i = 0; i < n_rec; i++)
                begin
                    case ($urandom_range(3))
                        0: rtype = want_type;
                        1: rtype = 16'd1;
                        2: rtype = 16'd28;
                        default: rtype = 16'($urandom_range(65535));
                    endcase
                    case ($urandom_range(7))
                        0: life = 32'h0000_0000;
                        1: life = 32'hFFFF_FFFF;
                        default: life = $urandom;
                    endcase
                    if ($urandom_range(9) < 7)
                        dlen = 4;
                    else if ($urandom_range(9) == 0)
                        dlen = $urandom_range(10, 40);
                    else
                        dlen = $urandom_range(0, 9);
                    add_record(rtype, life, dlen);
                end
                if ($urandom_range(9) == 0)
                    add_noise($urandom_range(1, 6));
                keep = 0;
                if ($urandom_range(9) == 0)
                    keep = $urandom_range(1, msg_q.size());
                send_message(keep);
            end
            // occasional change of record type, only when the parser is idle
            if ($urandom_range(11) == 0)
            begin
                settle_parser();
                case ($urandom_range(4))
                    0: write_wanted_type(16'h0000);
                    1: write_wanted_type(16'hFFFF);
                    2: write_wanted_type(16'd28);
                    3: write_wanted_type(16'd1);
                    default: write_wanted_type(16'($urandom_range(65535)));
                endcase
            end
        end
        settle_parser();
    endtask

    initial
    begin
        clear_parse_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 19;
        recv_idle_pct = 80;
        test_short_messages();
        test_basic_records();
        test_data_lengths();
        test_cut_off();
        test_type_config();
        test_oversize();

        test_random(19, 80, 250);
        test_random(80, 19, 250);
        test_random(0, 0, 250);

        settle_parser();
        if (results_due.size() != 0)
            report_mismatch($sformatf("%0d predicted results never came", results_due.size()));

        $display("sent %0d messages (%0d bytes) over %0d record type settings",
                 messages_sent, bytes_sent, type_settings);
        $display("checked %0d record results and %0d message summaries, %0d mismatches",
                 records_seen, summaries_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/dnsarp_pkg.sv
src/dns_answer_record_parser.sv
test/tb.sv
